### src/srtf_pkg.sv
// srtf_pkg: shared widths, operation codes and the slot word layout for the
// shortest-remaining-time-first scheduler core.
// No dependencies.
`default_nettype none

package srtf_pkg;

  localparam int VAL_W   = 16;  // arrival, burst and remaining time
  localparam int TIME_W  = 32;  // time counter and reported times
  localparam int COUNT_W = 5;   // process_count register
  localparam int SLOT_W  = 4;   // slot field of a transaction

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // one entry of the slot memory
  typedef struct packed {
    logic [VAL_W-1:0] arr;
    logic [VAL_W-1:0] bur;
    logic [VAL_W-1:0] rem;
  } slot_word_t;

endpackage

`default_nettype wire

### src/srtf_ram.sv
// srtf_ram: generic simple dual-port RAM, one write port and one read port
// with registered read data. No dependencies.
`default_nettype none

module srtf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/srtf_tick_scheduler_core.sv
// srtf_tick_scheduler_core: top level of the shortest-remaining-time-first
// scheduler. Uses srtf_pkg and one srtf_ram instance for the slot store.
//
// Each input transaction is either a load (op 0), which writes one slot's
// arrival and burst time and restarts the run, or a tick (op 1), which serves
// the arrived, unfinished slot with the least remaining time (lowest slot on
// a tie) for one time unit. Both kinds sweep the slot memory one slot per
// cycle through its single read port; a tick then updates the served slot,
// and when that slot finishes the turnaround and waiting times go through
// the shared subtractor before the result is emitted. in_ready is low while a
// transaction is being worked on; a finished result waits in the output
// register and the next transaction is accepted meanwhile. process_count is
// written through cfg_we / cfg_wdata; the user must do so only while the
// block is idle, as the block itself does not enforce it.
`default_nettype none

module srtf_tick_scheduler_core #(
  parameter int MAX_SLOTS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [srtf_pkg::COUNT_W-1:0]   cfg_wdata,
  // input channel
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic                           op,
  input  wire logic [srtf_pkg::SLOT_W-1:0]    slot,
  input  wire logic [srtf_pkg::VAL_W-1:0]     arrival_time,
  input  wire logic [srtf_pkg::VAL_W-1:0]     burst_time,
  // output channel
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic                           ran,
  output      logic [srtf_pkg::SLOT_W-1:0]    running_slot,
  output      logic                           finished,
  output      logic [srtf_pkg::TIME_W-1:0]    completion_time,
  output      logic [srtf_pkg::TIME_W-1:0]    turnaround_time,
  output      logic [srtf_pkg::TIME_W-1:0]    waiting_time,
  output      logic                           all_done,
  output      logic [srtf_pkg::TIME_W-1:0]    current_time
);

  localparam int SW     = $clog2(MAX_SLOTS);
  localparam int IDX_W  = SW + 1;
  localparam int CNT_W  = (IDX_W > srtf_pkg::COUNT_W) ? IDX_W : srtf_pkg::COUNT_W;
  localparam int WORD_W = $bits(srtf_pkg::slot_word_t);
  localparam int VW     = srtf_pkg::VAL_W;
  localparam int TW     = srtf_pkg::TIME_W;

  localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(MAX_SLOTS);
  localparam logic [TW-1:0]    TIME_TOP = '1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_TAT  = 3'd4;
  localparam logic [2:0] ST_WT   = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [srtf_pkg::COUNT_W-1:0] process_count;
  logic [MAX_SLOTS-1:0]         done;
  logic [TW-1:0]                time_counter;

  // captured transaction
  logic                          cur_op;
  logic [srtf_pkg::SLOT_W-1:0]   cur_slot;
  logic [VW-1:0]                 cur_arr;
  logic [VW-1:0]                 cur_bur;

  // sweep control
  logic [IDX_W-1:0] idx;
  logic             pend_vld;
  logic [SW-1:0]    pend_idx;
  logic [1:0]       pending;   // unfinished slots in use, saturating at two

  // scan result
  logic          found;
  logic [SW-1:0] best_idx;
  logic [VW-1:0] best_rem;
  logic [VW-1:0] best_arr;
  logic [VW-1:0] best_bur;
  logic          fin;
  logic [TW-1:0] tat_q;
  logic [TW-1:0] wt_q;

  // memory port signals
  logic                    ram_we;
  logic [SW-1:0]           ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic                    ram_re;
  logic [WORD_W-1:0]       ram_rdata;
  srtf_pkg::slot_word_t    rd_word;
  srtf_pkg::slot_word_t    load_word;

  logic          sweep_last;
  logic          in_use;
  logic          slot_hit;
  logic          eligible;
  logic [VW-1:0] new_rem;
  logic [CNT_W-1:0] best_ext;
  logic          emit_go;

  // shared subtractor: turnaround, then waiting time
  logic [TW-1:0] sub_a;
  logic [TW-1:0] sub_b;
  logic [TW:0]   sub_full;

  srtf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx[SW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_word    = srtf_pkg::slot_word_t'(ram_rdata);
  assign in_ready   = (state == ST_IDLE);
  assign sweep_last = pend_vld && (idx == IDX_END);
  assign in_use     = CNT_W'(pend_idx) < CNT_W'(process_count);
  assign slot_hit   = CNT_W'(pend_idx) == CNT_W'(cur_slot);
  assign eligible   = in_use && !done[pend_idx]
                      && ({{(TW-VW){1'b0}}, rd_word.arr} <= time_counter)
                      && (!found || (rd_word.rem < best_rem));
  assign new_rem    = (best_rem != '0) ? best_rem - VW'(1) : '0;
  assign best_ext   = CNT_W'(best_idx);
  assign emit_go    = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    load_word.arr = slot_hit ? cur_arr : rd_word.arr;
    load_word.bur = slot_hit ? cur_bur : rd_word.bur;
    load_word.rem = load_word.bur;
  end

  always_comb begin
    ram_re    = ((state == ST_LOAD) || (state == ST_SCAN)) && (idx != IDX_END);
    ram_we    = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = load_word;
    if ((state == ST_LOAD) && pend_vld) begin
      ram_we = 1'b1;
    end else if ((state == ST_UPD) && found) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = {best_arr, best_bur, new_rem};
    end
  end

  always_comb begin
    if (state == ST_TAT) begin
      sub_a = time_counter;
      sub_b = {{(TW-VW){1'b0}}, best_arr};
    end else begin
      sub_a = tat_q;
      sub_b = {{(TW-VW){1'b0}}, best_bur};
    end
    sub_full = {1'b0, sub_a} - {1'b0, sub_b};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (op == srtf_pkg::OP_LOAD) ? ST_LOAD : ST_SCAN;
        end
      end
      ST_LOAD: begin
        if (sweep_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (sweep_last) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        state_next = (found && (new_rem == '0)) ? ST_TAT : ST_EMIT;
      end
      ST_TAT:  state_next = ST_WT;
      ST_WT:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      process_count <= '0;
      done          <= '0;
      time_counter  <= '0;
      idx           <= '0;
      pend_vld      <= 1'b0;
      found         <= 1'b0;
      fin           <= 1'b0;
      pending       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        process_count <= cfg_wdata;
      end

      if (in_valid && in_ready) begin
        idx      <= '0;
        pend_vld <= 1'b0;
        found    <= 1'b0;
        fin      <= 1'b0;
        pending  <= '0;
      end

      if ((state == ST_LOAD) || (state == ST_SCAN)) begin
        pend_vld <= ram_re;
        if (ram_re) begin
          idx <= idx + IDX_W'(1);
        end
      end

      // restart sweep: remaining back to burst, zero burst counts as done
      if ((state == ST_LOAD) && pend_vld) begin
        done[pend_idx] <= (load_word.bur == '0);
        if (in_use && (load_word.bur != '0) && (pending != 2'd2)) begin
          pending <= pending + 2'd1;
        end
        if (sweep_last) begin
          time_counter <= '0;
        end
      end

      if ((state == ST_SCAN) && pend_vld) begin
        if (in_use && !done[pend_idx] && (pending != 2'd2)) begin
          pending <= pending + 2'd1;
        end
        if (eligible) begin
          found <= 1'b1;
        end
      end

      if (state == ST_UPD) begin
        if (time_counter != TIME_TOP) begin
          time_counter <= time_counter + TW'(1);
        end
        if (found && (new_rem == '0)) begin
          done[best_idx] <= 1'b1;
          fin            <= 1'b1;
        end
      end

      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_op   <= op;
      cur_slot <= slot;
      cur_arr  <= arrival_time;
      cur_bur  <= burst_time;
    end
    if (((state == ST_LOAD) || (state == ST_SCAN)) && ram_re) begin
      pend_idx <= idx[SW-1:0];
    end
    if ((state == ST_SCAN) && pend_vld && eligible) begin
      best_idx <= pend_idx;
      best_rem <= rd_word.rem;
      best_arr <= rd_word.arr;
      best_bur <= rd_word.bur;
    end
    if (state == ST_TAT) begin
      tat_q <= sub_full[TW-1:0];
    end
    // waiting time clamps at zero on a borrow
    if (state == ST_WT) begin
      wt_q <= sub_full[TW] ? '0 : sub_full[TW-1:0];
    end
    if (emit_go) begin
      ran             <= (cur_op == srtf_pkg::OP_TICK) && found;
      running_slot    <= ((cur_op == srtf_pkg::OP_TICK) && found) ?
                         best_ext[srtf_pkg::SLOT_W-1:0] : '0;
      finished        <= fin;
      completion_time <= fin ? time_counter : '0;
      turnaround_time <= fin ? tat_q : '0;
      waiting_time    <= fin ? wt_q : '0;
      all_done        <= (pending == 2'd0) || ((pending == 2'd1) && fin);
      current_time    <= time_counter;
    end
  end

  // a transaction holds the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted transaction");

  a_finish_needs_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!finished || ran))
    else $error("finished reported without a served slot");

  a_wait_le_turnaround: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> (waiting_time <= turnaround_time))
    else $error("waiting time exceeds turnaround time");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) || (state == ST_EMIT) |-> !ram_we)
    else $error("slot memory written outside a sweep or update");

  a_idle_tick_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ran |-> (completion_time == '0) && (running_slot == '0))
    else $error("idle or load result carries slot data");

endmodule

`default_nettype wire

### dv/tb_srtf_tick_scheduler_core.sv
// tb_srtf_tick_scheduler_core: self-checking testbench for the srtf tick scheduler core.
// Depends on srtf_pkg and srtf_tick_scheduler_core; directed table first, then random
// load/tick runs checked against an in-bench scheduler model.
`timescale 1ns / 1ps

module tb_srtf_tick_scheduler_core;

  localparam int SLOT_W  = srtf_pkg::SLOT_W;
  localparam int TIME_W  = srtf_pkg::TIME_W;
  localparam int COUNT_W = srtf_pkg::COUNT_W;
  localparam int VAL_W   = srtf_pkg::VAL_W;

  localparam int NUM_SLOTS   = 16;
  localparam int ITEMS_TOTAL = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 2 * NUM_SLOTS + 10;
  localparam int TICK_CAP    = 50;
  localparam int DIR_N       = 29;

  typedef struct packed {
    logic              ran;
    logic [SLOT_W-1:0] running_slot;
    logic              finished;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic [TIME_W-1:0] clock_now;
  } sched_result_t;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [COUNT_W-1:0] count;
    logic               op;
    logic [SLOT_W-1:0]  slot;
    logic [VAL_W-1:0]   arr;
    logic [VAL_W-1:0]   bur;
    logic               typed;
    sched_result_t      want;
  } stim_row_t;

  // results that can be read off directly
  localparam sched_result_t RES_LOAD_ALL_DONE = '{1'b0, 4'd0, 1'b0, 32'd0, 32'd0, 32'd0,
                                                  1'b1, 32'd0};
  localparam sched_result_t RES_IDLE_T1       = '{1'b0, 4'd0, 1'b0, 32'd0, 32'd0, 32'd0,
                                                  1'b1, 32'd1};
  localparam sched_result_t RES_LOAD_PENDING  = '0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                op = srtf_pkg::OP_LOAD;
  logic [SLOT_W-1:0]   slot = '0;
  logic [VAL_W-1:0]    arrival_time = '0;
  logic [VAL_W-1:0]    burst_time = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                ran;
  logic [SLOT_W-1:0]   running_slot;
  logic                finished;
  logic [TIME_W-1:0]   completion_time;
  logic [TIME_W-1:0]   turnaround_time;
  logic [TIME_W-1:0]   waiting_time;
  logic                all_done;
  logic [TIME_W-1:0]   current_time;

  srtf_tick_scheduler_core #(
    .MAX_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .slot            (slot),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ran             (ran),
    .running_slot    (running_slot),
    .finished        (finished),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time),
    .all_done        (all_done),
    .current_time    (current_time)
  );

  // scheduler model state
  logic [VAL_W-1:0]   slot_rem [NUM_SLOTS];
  logic [VAL_W-1:0]   slot_arr [NUM_SLOTS];
  logic [VAL_W-1:0]   slot_bur [NUM_SLOTS];
  bit                 slot_done [NUM_SLOTS];
  logic [TIME_W-1:0]  sched_clock = '0;
  logic [COUNT_W-1:0] proc_count = '0;

  sched_result_t pending_results [$];
  int            err_cnt = 0;
  int            items_sent = 0;
  int            cycle_cnt = 0;
  bit            quiet = 1'b0;
  bit            hold_req = 1'b0;

  stim_row_t dir_tab [DIR_N] = '{
    '{ROW_CFG, 5'd0, srtf_pkg::OP_LOAD, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    // fill every slot while no slot is in use
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd0, 16'h0000, 16'h0003, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd1, 16'h0001, 16'h0001, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd2, 16'h0000, 16'h0002, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd3, 16'hFFFF, 16'hFFFF, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd4, 16'h0000, 16'h0000, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd5, 16'h0002, 16'h0005, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd6, 16'h0000, 16'hFFFF, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd7, 16'h8000, 16'h0001, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd8, 16'h0005, 16'h0002, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd9, 16'h0000, 16'h0004, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd10, 16'h0003, 16'h0003, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd11, 16'h0000, 16'h0001, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd12, 16'h0007, 16'h0000, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd13, 16'h0001, 16'h0006, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd14, 16'h7FFF, 16'h7FFF, 1'b1, RES_LOAD_ALL_DONE},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd15, 16'h0000, 16'h0001, 1'b1, RES_LOAD_ALL_DONE},
    // no slot in use: idle tick still moves time
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 1'b1, RES_IDLE_T1},
    '{ROW_CFG, 5'd5, srtf_pkg::OP_LOAD, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    // zero burst reload restarts the run, slot 4 already complete
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd4, 16'h0000, 16'h0000, 1'b1, RES_LOAD_PENDING},
    // ties, late arrival and finishes
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    // count above the slot limit acts as all slots
    '{ROW_CFG, 5'd31, srtf_pkg::OP_LOAD, 4'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_LOAD, 4'd0, 16'h0000, 16'h0001, 1'b0, '0},
    '{ROW_ITEM, 5'd0, srtf_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, '0}
  };

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int slots_in_use();
    return (proc_count > NUM_SLOTS) ? NUM_SLOTS : int'(proc_count);
  endfunction

  function automatic bit all_slots_done();
    bit d;
    d = 1'b1;
    for (int j = 0; j < slots_in_use(); j++)
      if (!slot_done[j]) d = 1'b0;
    return d;
  endfunction

  // one load or tick applied to the scheduler state
  function automatic sched_result_t srtf_next_result(input logic op_i,
                                                     input logic [SLOT_W-1:0] slot_i,
                                                     input logic [VAL_W-1:0] arr_i,
                                                     input logic [VAL_W-1:0] bur_i);
    sched_result_t    r;
    bit               found;
    int               pick;
    logic [VAL_W-1:0] pick_rem;
    logic [TIME_W-1:0] turn;
    r = '0;
    if (op_i == srtf_pkg::OP_LOAD) begin
      slot_arr[slot_i] = arr_i;
      slot_bur[slot_i] = bur_i;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        slot_rem[j]  = slot_bur[j];
        slot_done[j] = (slot_bur[j] == '0);
      end
      sched_clock = '0;
    end else begin
      found = 1'b0;
      pick = 0;
      pick_rem = '0;
      for (int j = 0; j < slots_in_use(); j++) begin
        if (!slot_done[j] && {16'd0, slot_arr[j]} <= sched_clock &&
            (!found || slot_rem[j] < pick_rem)) begin
          found = 1'b1;
          pick = j;
          pick_rem = slot_rem[j];
        end
      end
      if (sched_clock != '1) sched_clock = sched_clock + 1'b1;
      if (found) begin
        r.ran = 1'b1;
        r.running_slot = pick[SLOT_W-1:0];
        if (slot_rem[pick] != '0) slot_rem[pick] = slot_rem[pick] - 1'b1;
        if (slot_rem[pick] == '0) begin
          slot_done[pick] = 1'b1;
          r.finished = 1'b1;
          r.completion = sched_clock;
          turn = sched_clock - {16'd0, slot_arr[pick]};
          r.turnaround = turn;
          r.waiting = (turn >= {16'd0, slot_bur[pick]}) ? turn - {16'd0, slot_bur[pick]} : '0;
        end
      end
    end
    r.all_done = all_slots_done();
    r.clock_now = sched_clock;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  task automatic send_item(input logic op_i, input logic [SLOT_W-1:0] slot_i,
                           input logic [VAL_W-1:0] arr_i, input logic [VAL_W-1:0] bur_i,
                           input logic typed_i, input sched_result_t want_i);
    sched_result_t p;
    int            g;
    g = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= op_i;
    slot         <= slot_i;
    arrival_time <= arr_i;
    burst_time   <= bur_i;
    do @(posedge clk); while (!in_ready);
    p = srtf_next_result(op_i, slot_i, arr_i, bur_i);
    pending_results = {pending_results, (typed_i ? want_i : p)};
    items_sent++;
  endtask

  // register write only once every result is out
  task automatic write_count(input logic [COUNT_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    proc_count = v;
  endtask

  // stimulus
  initial begin
    int               r;
    int               n;
    int               in_use;
    int               base;
    int               ticks;
    int               extra;
    logic [SLOT_W-1:0] s;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      slot_rem[j] = '0;
      slot_arr[j] = '0;
      slot_bur[j] = '0;
      slot_done[j] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_count(dir_tab[i].count);
      else
        send_item(dir_tab[i].op, dir_tab[i].slot, dir_tab[i].arr, dir_tab[i].bur,
                  dir_tab[i].typed, dir_tab[i].want);
    end

    while (items_sent < ITEMS_TOTAL) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = int'($urandom_range(0, 15));
      if (r == 0) n = 0;
      else if (r == 1) n = int'($urandom_range(17, 31));
      else if (r < 4) n = int'($urandom_range(9, 16));
      else n = int'($urandom_range(1, 8));
      write_count(n[COUNT_W-1:0]);
      in_use = (n > NUM_SLOTS) ? NUM_SLOTS : n;

      // sometimes a stray load to any slot, with full-width random values
      if (in_use == 0 || $urandom_range(0, 2) == 0) begin
        s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        a = VAL_W'($urandom());
        b = VAL_W'($urandom());
        send_item(srtf_pkg::OP_LOAD, s, a, b, 1'b0, '0);
      end
      // reload every slot in use, starting at a random one
      base = int'($urandom_range(0, NUM_SLOTS - 1));
      for (int k = 0; k < in_use; k++) begin
        s = SLOT_W'((base + k) % in_use);
        if ($urandom_range(0, 24) == 0) begin
          a = VAL_W'($urandom());
          b = VAL_W'($urandom());
        end else begin
          a = VAL_W'($urandom_range(0, 12));
          b = VAL_W'($urandom_range(0, 6));
        end
        send_item(srtf_pkg::OP_LOAD, s, a, b, 1'b0, '0);
      end

      ticks = 0;
      while (!all_slots_done() && ticks < TICK_CAP) begin
        if (in_use != 0 && $urandom_range(0, 39) == 0) begin
          // restart in the middle of a run
          s = SLOT_W'($urandom_range(0, in_use - 1));
          a = VAL_W'($urandom_range(0, 12));
          b = VAL_W'($urandom_range(0, 6));
          send_item(srtf_pkg::OP_LOAD, s, a, b, 1'b0, '0);
        end else begin
          send_item(srtf_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 1'b0, '0);
        end
        ticks++;
      end

      extra = int'($urandom_range(1, 3));
      if (!hold_req && items_sent >= ITEMS_TOTAL / 2) begin
        // receiver goes quiet for a long time while ticks keep coming
        hold_req = 1'b1;
        extra = 8;
      end
      for (int k = 0; k < extra; k++) begin
        s = SLOT_W'($urandom());
        send_item(srtf_pkg::OP_TICK, s, 16'd0, 16'd0, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) err_cnt++;
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result receiver with random back-pressure
  initial begin
    int hold_cnt;
    int stall_cnt;
    bit hold_taken;
    hold_cnt = 0;
    stall_cnt = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cnt = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall_cnt = gap_len();
      end
    end
  end

  // result check
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t e;
    if (!rst && out_valid && out_ready) begin
      got = '{ran, running_slot, finished, completion_time, turnaround_time, waiting_time,
              all_done, current_time};
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected transaction: ran=%0d slot=%0d fin=%0d t=%0d",
                   ran, running_slot, finished, current_time);
      end else begin
        e = pending_results.pop_front();
        if (got.ran !== e.ran || got.running_slot !== e.running_slot ||
            got.finished !== e.finished || got.completion !== e.completion ||
            got.turnaround !== e.turnaround || got.waiting !== e.waiting ||
            got.all_done !== e.all_done || got.clock_now !== e.clock_now) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch exp: ran=%0d slot=%0d fin=%0d ct=%0d tat=%0d wt=%0d",
                     e.ran, e.running_slot, e.finished, e.completion, e.turnaround,
                     e.waiting);
            $display("              done=%0d t=%0d", e.all_done, e.clock_now);
            $display("         got: ran=%0d slot=%0d fin=%0d ct=%0d tat=%0d wt=%0d",
                     got.ran, got.running_slot, got.finished, got.completion,
                     got.turnaround, got.waiting);
            $display("              done=%0d t=%0d", got.all_done, got.clock_now);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

### sim.f
src/srtf_pkg.sv
src/srtf_ram.sv
src/srtf_tick_scheduler_core.sv
dv/tb_srtf_tick_scheduler_core.sv
